// ----- sv/pressure_temperature_compensation_core_macros.svh -----
// Assertion helpers shared by the compensation core.
// Both sample on the rising edge of clk and are held off while arst_n is low.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH

// Same-cycle implication
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ptc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		IDX_SENS       = 3'd0,
		IDX_OFFSET     = 3'd1,
		IDX_SENS_TEMP  = 3'd2,
		IDX_OFFSET_TMP = 3'd3,
		IDX_REF_TEMP   = 3'd4,
		IDX_TEMP_SLOPE = 3'd5,
		IDX_MODEL      = 3'd6
	} cfg_idx_t;

	// Sensor model codes
	localparam logic MODEL_30BAR = 1'b0;
	localparam logic MODEL_2BAR  = 1'b1;

	// Power-of-two scalings of the compensation formulae
	localparam int unsigned SENS_SH_2BAR  = 7;
	localparam int unsigned SENS_SH_30BAR = 8;
	localparam int unsigned OFF_SH_2BAR   = 6;
	localparam int unsigned OFF_SH_30BAR  = 7;
	localparam int unsigned TEMP_SH       = 23;
	localparam int unsigned PROD_SH       = 21;
	localparam int unsigned P_SH_2BAR     = 15;
	localparam int unsigned P_SH_30BAR    = 13;
	localparam int          TEMP_BASE     = 2000;

	// Calibration register file
	typedef struct packed {
		logic [15:0] sens_coeff;
		logic [15:0] offset_coeff;
		logic [15:0] sens_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temp;
		logic [15:0] temp_slope;
		logic        sensor_model;
	} cfg_t;

	// Per-stage load enables
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
		logic en_s7;
	} stage_en_t;

	// Signed division by 2^sh, truncating toward zero
	function automatic logic signed [63:0] div_pow2(input logic signed [63:0] x,
			input int unsigned sh);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (x + bias) >>> sh;
	endfunction

endpackage

`default_nettype wire

// ----- sv/pressure_temperature_compensation_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// First-order temperature compensation of a 24-bit pressure/temperature pair.
// Input stream (s_*): one word per reading pair, raw pressure and raw
// temperature. Output stream (m_*): one word per input word, compensated
// pressure and temperature in hundredths of a degree, in input order.
// Configuration channel (cfg_*): index 0..6 selects C1..C6 or the sensor
// model; it is always ready and must only be written while the core is idle.
// A word accepted on s_* passes seven register stages before it is offered on
// m_* (dT, coefficient products, SENS/OFF/TEMP, two partial products of
// D1 * SENS, recombination, D1 * SENS / 2^21, OFF subtraction and scaling).
// Throughput: one word per cycle while m_tready is high.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// are squeezed out and s_tready stays high while the result waits, until all
// seven stages hold a word. A stall loses and repeats nothing.
// Reset clears every stage valid bit and all calibration registers to zero.
module pressure_temperature_compensation_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [26:0] pressure, [45:27] temperature, rest zero
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	ptc_pkg::cfg_t      cfg_q;
	ptc_pkg::stage_en_t en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [23:0]        d1_s3;
	logic signed [35:0] sens_s3;
	logic signed [35:0] off_s3;
	logic signed [18:0] temp_s3;
	logic signed [26:0] pressure_s7;
	logic signed [18:0] temperature_s7;

	// Calibration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (ptc_pkg::cfg_idx_t'(cfg_index))
				ptc_pkg::IDX_SENS:       cfg_q.sens_coeff        <= cfg_data;
				ptc_pkg::IDX_OFFSET:     cfg_q.offset_coeff      <= cfg_data;
				ptc_pkg::IDX_SENS_TEMP:  cfg_q.sens_temp_coeff   <= cfg_data;
				ptc_pkg::IDX_OFFSET_TMP: cfg_q.offset_temp_coeff <= cfg_data;
				ptc_pkg::IDX_REF_TEMP:   cfg_q.reference_temp    <= cfg_data;
				ptc_pkg::IDX_TEMP_SLOPE: cfg_q.temp_slope        <= cfg_data;
				ptc_pkg::IDX_MODEL:      cfg_q.sensor_model      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when empty or when its successor loads
	always_comb begin
		en.en_s7 = !v_s7 || m_tready;
		en.en_s6 = !v_s6 || en.en_s7;
		en.en_s5 = !v_s5 || en.en_s6;
		en.en_s4 = !v_s4 || en.en_s5;
		en.en_s3 = !v_s3 || en.en_s4;
		en.en_s2 = !v_s2 || en.en_s3;
		en.en_s1 = !v_s1 || en.en_s2;
	end

	assign s_tready = en.en_s1;

	// Valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en.en_s1) v_s1 <= s_tvalid;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
			if (en.en_s4) v_s4 <= v_s3;
			if (en.en_s5) v_s5 <= v_s4;
			if (en.en_s6) v_s6 <= v_s5;
			if (en.en_s7) v_s7 <= v_s6;
		end
	end

	ptc_front u_front (
		.clk             (clk),
		.en              (en),
		.cfg             (cfg_q),
		.raw_pressure    (s_tdata[23:0]),
		.raw_temperature (s_tdata[47:24]),
		.d1_s3           (d1_s3),
		.sens_s3         (sens_s3),
		.off_s3          (off_s3),
		.temp_s3         (temp_s3)
	);

	ptc_back u_back (
		.clk            (clk),
		.en             (en),
		.sensor_model   (cfg_q.sensor_model),
		.d1_s3          (d1_s3),
		.sens_s3        (sens_s3),
		.off_s3         (off_s3),
		.temp_s3        (temp_s3),
		.pressure_s7    (pressure_s7),
		.temperature_s7 (temperature_s7)
	);

	// Output word
	assign m_tvalid = v_s7;
	assign m_tdata  = {2'b00, temperature_s7, pressure_s7};

	`include "pressure_temperature_compensation_core_macros.svh"

	// Input is refused only when every stage is full and the output stalls
	`PTC_ASSERT_NOW(a_full_when_blocked, !s_tready, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && !m_tready, "input refused with room in the pipeline")
	// An accepted word lands in stage 1
	`PTC_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, v_s1, "accepted word not captured")
	// A word behind a stalled output is kept
	`PTC_ASSERT_NEXT(a_stall_keeps_s6, v_s6 && v_s7 && !m_tready, v_s6 && v_s7, "word lost behind stalled output")
	// Model register takes bit 0 of the write data
	`PTC_ASSERT_NEXT(a_model_write, cfg_valid && cfg_ready && cfg_index == ptc_pkg::IDX_MODEL, cfg_q.sensor_model == $past(cfg_data[0]), "model register write mismatch")

endmodule

`default_nettype wire

// ----- sv/ptc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stages 1 to 3: temperature difference, coefficient products, SENS/OFF/TEMP
module ptc_front (
	input  wire logic               clk,
	input  wire ptc_pkg::stage_en_t en,
	input  wire ptc_pkg::cfg_t      cfg,
	input  wire logic [23:0]        raw_pressure,
	input  wire logic [23:0]        raw_temperature,
	output logic [23:0]             d1_s3,
	output logic signed [35:0]      sens_s3,
	output logic signed [35:0]      off_s3,
	output logic signed [18:0]      temp_s3
);

	logic [23:0]        d1_s1;
	logic signed [24:0] dt_s1;
	logic [23:0]        d1_s2;
	logic signed [41:0] c3dt_s2;
	logic signed [41:0] c4dt_s2;
	logic signed [41:0] c6dt_s2;

	logic signed [63:0] sens_frac;
	logic signed [63:0] off_frac;
	logic signed [63:0] temp_full;
	logic [35:0]        sens_base;
	logic [35:0]        off_base;
	logic               is_2bar;

	// Stage 1: dT = D2 - C5 * 256
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.reference_temp, 8'h00});
		end
	end

	// Stage 2: the three coefficient products on dT
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			d1_s2   <= d1_s1;
			c3dt_s2 <= dt_s1 * $signed({1'b0, cfg.sens_temp_coeff});
			c4dt_s2 <= dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
			c6dt_s2 <= dt_s1 * $signed({1'b0, cfg.temp_slope});
		end
	end

	// Stage 3: scale and add the base terms for the selected model
	always_comb begin
		is_2bar   = (cfg.sensor_model == ptc_pkg::MODEL_2BAR);
		sens_frac = ptc_pkg::div_pow2(64'(c3dt_s2),
			is_2bar ? ptc_pkg::SENS_SH_2BAR : ptc_pkg::SENS_SH_30BAR);
		off_frac  = ptc_pkg::div_pow2(64'(c4dt_s2),
			is_2bar ? ptc_pkg::OFF_SH_2BAR : ptc_pkg::OFF_SH_30BAR);
		sens_base = is_2bar ? 36'({cfg.sens_coeff, 16'h0000})
			: 36'({cfg.sens_coeff, 15'h0000});
		off_base  = is_2bar ? 36'({cfg.offset_coeff, 17'h00000})
			: 36'({cfg.offset_coeff, 16'h0000});
		temp_full = ptc_pkg::div_pow2(64'(c6dt_s2), ptc_pkg::TEMP_SH)
			+ 64'(ptc_pkg::TEMP_BASE);
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			d1_s3   <= d1_s2;
			sens_s3 <= $signed(sens_base) + $signed(sens_frac[35:0]);
			off_s3  <= $signed(off_base) + $signed(off_frac[35:0]);
			temp_s3 <= $signed(temp_full[18:0]);
		end
	end

endmodule

`default_nettype wire

// ----- sv/ptc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stages 4 to 7: D1 * SENS in two partial products, then the pressure result
module ptc_back (
	input  wire logic               clk,
	input  wire ptc_pkg::stage_en_t en,
	input  wire logic               sensor_model,
	input  wire logic [23:0]        d1_s3,
	input  wire logic signed [35:0] sens_s3,
	input  wire logic signed [35:0] off_s3,
	input  wire logic signed [18:0] temp_s3,
	output logic signed [26:0]      pressure_s7,
	output logic signed [18:0]      temperature_s7
);

	logic signed [43:0] pp_lo_s4;
	logic signed [42:0] pp_hi_s4;
	logic signed [35:0] off_s4;
	logic signed [18:0] temp_s4;
	logic signed [60:0] prod_s5;
	logic signed [35:0] off_s5;
	logic signed [18:0] temp_s5;
	logic signed [39:0] q_s6;
	logic signed [35:0] off_s6;
	logic signed [18:0] temp_s6;

	logic signed [63:0] q_full;
	logic signed [63:0] p_full;

	// Stage 4: partial products on the low and high halves of SENS
	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			pp_lo_s4 <= $signed({1'b0, d1_s3}) * $signed({1'b0, sens_s3[17:0]});
			pp_hi_s4 <= $signed({1'b0, d1_s3}) * $signed(sens_s3[35:18]);
			off_s4   <= off_s3;
			temp_s4  <= temp_s3;
		end
	end

	// Stage 5: recombine the full product
	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			prod_s5 <= (61'(pp_hi_s4) <<< 18) + 61'(pp_lo_s4);
			off_s5  <= off_s4;
			temp_s5 <= temp_s4;
		end
	end

	// Stage 6: D1 * SENS / 2^21
	assign q_full = ptc_pkg::div_pow2(64'(prod_s5), ptc_pkg::PROD_SH);

	always_ff @(posedge clk) begin
		if (en.en_s6) begin
			q_s6    <= $signed(q_full[39:0]);
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
		end
	end

	// Stage 7: subtract OFF and scale to the model's pressure unit
	assign p_full = ptc_pkg::div_pow2(64'(q_s6) - 64'(off_s6),
		(sensor_model == ptc_pkg::MODEL_2BAR) ? ptc_pkg::P_SH_2BAR : ptc_pkg::P_SH_30BAR);

	always_ff @(posedge clk) begin
		if (en.en_s7) begin
			pressure_s7    <= $signed(p_full[26:0]);
			temperature_s7 <= temp_s6;
		end
	end

endmodule

`default_nettype wire
